// ----- hdl/wpd_pkg.sv -----
// Shared types and constants for the wheel period and distance block.
package wpd_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 16;
  localparam int unsigned PERIOD_W          = 16;
  localparam int unsigned CFG_ADDR_W        = 4;
  localparam int unsigned CFG_DATA_W        = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] DIST_MAX   = 16'hFFFF;

  localparam logic [15:0] WHEEL_SIZE_RST = 16'd2000;
  localparam logic [15:0] DIST_STEP_RST  = 16'd10000;
  localparam logic [15:0] TIMEOUT_RST    = 16'd65535;

  localparam logic [1:0] REG_WHEEL_SIZE = 2'd0;
  localparam logic [1:0] REG_DIST_STEP  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  typedef struct packed {
    logic [15:0] wheel_size_mm;
    logic [15:0] distance_step_mm;
    logic [15:0] timeout_ticks;
  } wpd_cfg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_reading;
    logic                distance_step;
    logic                timed_out;
  } wpd_res_t;

endpackage

// ----- hdl/wpd_in_if.sv -----
// Input item channel: tick or pulse plus period select.
interface wpd_in_if;
  logic valid;
  logic ready;
  logic action;
  logic select_last;

  modport source (output valid, output action, output select_last, input ready);
  modport sink (input valid, input action, input select_last, output ready);
endinterface

// ----- hdl/wpd_out_if.sv -----
// Result item channel: period reading and event flags.
interface wpd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] period_reading;
  logic        distance_step;
  logic        timed_out;

  modport source (output valid, output period_reading, output distance_step,
                  output timed_out, input ready);
  modport sink (input valid, input period_reading, input distance_step,
                input timed_out, output ready);
endinterface

// ----- hdl/wpd_core.sv -----
// Period counter, filter and distance accumulator state with per-item update.
module wpd_core #(
  parameter int unsigned COUNTER_WIDTH = wpd_pkg::COUNTER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             action,
  input  logic             select_last,
  input  wpd_pkg::wpd_cfg_t cfg,
  output wpd_pkg::wpd_res_t res
);
  import wpd_pkg::*;

  localparam int unsigned EW = (COUNTER_WIDTH > PERIOD_W) ? COUNTER_WIDTH : PERIOD_W;

  logic [COUNTER_WIDTH-1:0] down_count_r, down_count_nxt;
  logic                     running_r, running_nxt;
  logic [PERIOD_W-1:0]      last_period_r, last_period_nxt;
  logic [PERIOD_W-1:0]      filtered_period_r, filtered_period_nxt;
  logic [PERIOD_W-1:0]      distance_mm_r, distance_mm_nxt;

  logic [COUNTER_WIDTH-1:0] reload;
  logic [EW-1:0]            diff;
  logic [PERIOD_W-1:0]      period;
  logic [PERIOD_W-1:0]      filt_new;
  logic [PERIOD_W:0]        dist_sum;
  logic [PERIOD_W:0]        dist_rem;
  logic                     step_hit;
  logic [PERIOD_W-1:0]      sel_period;

  always_comb begin
    reload   = COUNTER_WIDTH'(cfg.timeout_ticks);
    diff     = EW'(reload) - EW'(down_count_r);
    period   = diff[PERIOD_W-1:0];
    // 3/4 old + 1/4 new, each term pre-shifted
    filt_new = {1'b0, filtered_period_r[15:2], 1'b0} + 16'(filtered_period_r[15:2])
             + 16'(period[15:2]);

    dist_sum = 17'(distance_mm_r) + 17'(cfg.wheel_size_mm);
    step_hit = dist_sum > 17'(cfg.distance_step_mm);
    dist_rem = step_hit ? (dist_sum - 17'(cfg.distance_step_mm)) : dist_sum;

    down_count_nxt      = down_count_r;
    running_nxt         = running_r;
    last_period_nxt     = last_period_r;
    filtered_period_nxt = filtered_period_r;
    distance_mm_nxt     = distance_mm_r;
    res.distance_step   = 1'b0;
    res.timed_out       = 1'b0;

    if (action) begin
      down_count_nxt      = reload;
      running_nxt         = 1'b1;
      last_period_nxt     = period;
      filtered_period_nxt = filt_new;
      distance_mm_nxt     = dist_rem[PERIOD_W] ? DIST_MAX : dist_rem[PERIOD_W-1:0];
      res.distance_step   = step_hit;
    end else if (running_r) begin
      if (down_count_r == '0) begin
        running_nxt         = 1'b0;
        last_period_nxt     = PERIOD_MAX;
        filtered_period_nxt = PERIOD_MAX;
        res.timed_out       = 1'b1;
      end else begin
        down_count_nxt = down_count_r - 1'b1;
      end
    end

    sel_period         = select_last ? last_period_nxt : filtered_period_nxt;
    res.period_reading = (sel_period == '0) ? PERIOD_MAX : sel_period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_count_r      <= '0;
      running_r         <= 1'b0;
      last_period_r     <= PERIOD_MAX;
      filtered_period_r <= PERIOD_MAX;
      distance_mm_r     <= '0;
    end else if (accept) begin
      down_count_r      <= down_count_nxt;
      running_r         <= running_nxt;
      last_period_r     <= last_period_nxt;
      filtered_period_r <= filtered_period_nxt;
      distance_mm_r     <= distance_mm_nxt;
    end
  end

endmodule

// ----- hdl/wheel_period_and_distance.sv -----
// Top level: wheel pulse period measurement with filtered period and distance steps.
//
// in_ch carries one item per tick (action 0) or wheel pulse (action 1), with
// select_last choosing the raw last period or the filtered period for readback.
// Every accepted item gives exactly one result item on out_ch: the period
// reading after the item's update, a distance step flag and a timeout flag.
// The result is in the output register at the edge after acceptance. Throughput
// is one item per cycle while out_ch does not stall; state update and result are
// one pass of logic between the accepting edge and the output register.
// When out_ch stalls, the full output register holds and in_ch.ready drops
// until the result is taken; an item is accepted in the same cycle the held
// result leaves.
// The APB port (psel..pready) writes wheel size, step size and timeout at
// byte addresses 0, 4 and 8; write only while no item is in flight.
// Synchronous reset clears the counter and distance, stops the counter, sets
// both periods to 65535 and loads the register defaults 2000, 10000, 65535.
module wheel_period_and_distance #(
  parameter int unsigned COUNTER_WIDTH = wpd_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wpd_in_if.sink                          in_ch,
  wpd_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wpd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wpd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import wpd_pkg::*;

  wpd_cfg_t cfg_r;
  wpd_res_t res;
  wpd_res_t res_r;
  logic     out_valid_r;
  logic     accept;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_WHEEL_SIZE: prdata = 32'(cfg_r.wheel_size_mm);
      REG_DIST_STEP:  prdata = 32'(cfg_r.distance_step_mm);
      REG_TIMEOUT:    prdata = 32'(cfg_r.timeout_ticks);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_size_mm    <= WHEEL_SIZE_RST;
      cfg_r.distance_step_mm <= DIST_STEP_RST;
      cfg_r.timeout_ticks    <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WHEEL_SIZE: cfg_r.wheel_size_mm    <= pwdata[15:0];
        REG_DIST_STEP:  cfg_r.distance_step_mm <= pwdata[15:0];
        REG_TIMEOUT:    cfg_r.timeout_ticks    <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  wpd_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .action      (in_ch.action),
    .select_last (in_ch.select_last),
    .cfg         (cfg_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.period_reading = res_r.period_reading;
  assign out_ch.distance_step  = res_r.distance_step;
  assign out_ch.timed_out      = res_r.timed_out;

`ifndef SYNTHESIS
  a_pulse_no_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.action |=> out_ch.valid && !out_ch.timed_out)
    else $error("pulse item reported a timeout");

  a_tick_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.action |=> out_ch.valid && !out_ch.distance_step)
    else $error("tick item reported a distance step");

  a_reading_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.period_reading != '0)
    else $error("period reading of zero");

  a_timeout_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.timed_out |-> out_ch.period_reading == PERIOD_MAX)
    else $error("timeout item without cleared period");
`endif

endmodule
